// ===== hdl/pulse_width_manchester_frame_decoder_defines.svh =====
// assertion macros for the pulse width manchester frame decoder
`ifndef PULSE_WIDTH_MANCHESTER_FRAME_DECODER_DEFINES_SVH
`define PULSE_WIDTH_MANCHESTER_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PWMFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PWMFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pwmfd_pkg.sv =====
// shared types and constants of the pulse width manchester frame decoder
package pwmfd_pkg;

    localparam int unsigned CFG_W     = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned WIDTH_W   = 4;
    localparam int unsigned BIT_CNT_W = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BYTE_CNT_W = 3;
    localparam int unsigned FRAME_LEN = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WAKE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_MAX = 1'd1;

    localparam logic [CFG_W-1:0] WAKE_MIN_RST = 6'd5;
    localparam logic [CFG_W-1:0] WAKE_MAX_RST = 6'd40;

    localparam logic [WIDTH_W-1:0] W_1T = 4'd1;
    localparam logic [WIDTH_W-1:0] W_2T = 4'd2;
    localparam logic [WIDTH_W-1:0] W_3T = 4'd3;

    localparam logic [BIT_CNT_W-1:0]  BITS_PER_BYTE = 4'd8;
    localparam logic [BYTE_CNT_W-1:0] LAST_KEPT_BYTE = 3'd4;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_WAKE = 8'b0000_0010,
        ST_SYNC = 8'b0000_0100,
        ST_FILL = 8'b0000_1000,
        ST_LO12 = 8'b0001_0000,
        ST_HI1  = 8'b0010_0000,
        ST_HI12 = 8'b0100_0000,
        ST_LO1  = 8'b1000_0000
    } t_fsm_state;

    typedef struct packed {
        logic               req_type;
        logic               edge_rising;
        logic [WIDTH_W-1:0] pulse_len;
    } t_evt;

    typedef struct packed {
        logic                              message_ready;
        logic [FRAME_LEN-1:0][BYTE_W-1:0]  bytes;
    } t_frame_status;

endpackage

// ===== hdl/pwmfd_fsm.sv =====
// framing state machine, manchester bit decode and frame byte storage
module pwmfd_fsm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  pwmfd_pkg::t_evt                i_evt,
    input  logic [pwmfd_pkg::CFG_W-1:0]    i_wake_min,
    input  logic [pwmfd_pkg::CFG_W-1:0]    i_wake_max,
    output pwmfd_pkg::t_frame_status       o_status
);

    pwmfd_pkg::t_fsm_state r_state, n_state;
    logic [pwmfd_pkg::CFG_W-1:0]      r_wake, n_wake;
    logic [pwmfd_pkg::BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [pwmfd_pkg::BYTE_CNT_W-1:0] r_byte, n_byte;
    logic [pwmfd_pkg::BYTE_W-1:0]     r_shift, n_shift;
    logic [pwmfd_pkg::BYTE_W-1:0]     r_frame [pwmfd_pkg::FRAME_LEN];
    logic [pwmfd_pkg::BYTE_W-1:0]     n_frame [pwmfd_pkg::FRAME_LEN];
    logic                             r_ready, n_ready;

    logic                             bad;
    logic                             restart;
    logic                             push;
    logic                             push_one;
    logic                             rise;
    logic [pwmfd_pkg::WIDTH_W-1:0]    w;
    logic [pwmfd_pkg::BYTE_CNT_W-1:0] byte_inc;
    logic [pwmfd_pkg::BYTE_CNT_W-1:0] byte_slot;

    assign rise      = i_evt.edge_rising;
    assign w         = i_evt.pulse_len;
    assign byte_inc  = r_byte + 3'd1;
    assign byte_slot = byte_inc - 3'd1;

    always_comb begin
        n_state  = r_state;
        n_wake   = r_wake;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_frame  = r_frame;
        n_ready  = r_ready;
        bad      = 1'b0;
        restart  = 1'b0;
        push     = 1'b0;
        push_one = 1'b0;
        if (i_evt.req_type) begin
            n_ready = 1'b0;
            restart = 1'b1;
        end else if (!r_ready) begin
            unique case (r_state)
                pwmfd_pkg::ST_IDLE: begin
                    if (!rise) n_state = pwmfd_pkg::ST_WAKE;
                end
                pwmfd_pkg::ST_WAKE: begin
                    if (!rise && w == pwmfd_pkg::W_1T && r_wake < i_wake_max) begin
                        n_wake = r_wake + 6'd1;
                    end else if (!rise && w == pwmfd_pkg::W_3T && r_wake >= i_wake_min) begin
                        n_state = pwmfd_pkg::ST_SYNC;
                    end else begin
                        bad = 1'b1;
                    end
                end
                pwmfd_pkg::ST_SYNC: begin
                    if (rise && w == pwmfd_pkg::W_3T) n_state = pwmfd_pkg::ST_FILL;
                    else bad = 1'b1;
                end
                pwmfd_pkg::ST_FILL: begin
                    if (rise && w == pwmfd_pkg::W_1T) n_state = pwmfd_pkg::ST_LO12;
                    else bad = 1'b1;
                end
                pwmfd_pkg::ST_LO12: begin
                    if (rise && w == pwmfd_pkg::W_1T) begin
                        n_state = pwmfd_pkg::ST_HI1;
                    end else if (rise && w == pwmfd_pkg::W_2T) begin
                        push     = 1'b1;
                        push_one = 1'b1;
                        n_state  = pwmfd_pkg::ST_HI12;
                    end else begin
                        bad = 1'b1;
                    end
                end
                pwmfd_pkg::ST_HI1: begin
                    if (!rise && w == pwmfd_pkg::W_1T) begin
                        push    = 1'b1;
                        n_state = pwmfd_pkg::ST_LO12;
                    end else begin
                        bad = 1'b1;
                    end
                end
                pwmfd_pkg::ST_HI12: begin
                    if (!rise && w == pwmfd_pkg::W_1T) begin
                        n_state = pwmfd_pkg::ST_LO1;
                    end else if (!rise && w == pwmfd_pkg::W_2T) begin
                        push    = 1'b1;
                        n_state = pwmfd_pkg::ST_LO12;
                    end else begin
                        bad = 1'b1;
                    end
                end
                pwmfd_pkg::ST_LO1: begin
                    if (rise && w == pwmfd_pkg::W_1T) begin
                        push     = 1'b1;
                        push_one = 1'b1;
                        n_state  = pwmfd_pkg::ST_HI12;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: bad = 1'b1;
            endcase

            if (push) begin
                if (push_one && !r_bit[3]) n_shift = r_shift | (8'd1 << r_bit[2:0]);
                n_bit = r_bit + 4'd1;
            end

            if (bad) begin
                restart = 1'b1;
            end else if (n_bit == pwmfd_pkg::BITS_PER_BYTE) begin
                n_bit  = '0;
                n_byte = byte_inc;
                if (byte_inc != 3'd0 && byte_inc <= pwmfd_pkg::LAST_KEPT_BYTE) begin
                    n_frame[byte_slot[1:0]] = n_shift;
                end else begin
                    n_ready = 1'b1;
                    restart = 1'b1;
                end
                n_shift = '0;
            end
        end

        if (restart) begin
            n_state = pwmfd_pkg::ST_IDLE;
            n_wake  = '0;
            n_bit   = '0;
            n_byte  = '0;
            n_shift = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwmfd_pkg::ST_IDLE;
            r_wake  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_ready <= 1'b0;
            for (int i = 0; i < pwmfd_pkg::FRAME_LEN; i++) r_frame[i] <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
            r_wake  <= n_wake;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_ready <= n_ready;
            r_frame <= n_frame;
        end
    end

    always_comb begin
        o_status.message_ready = r_ready;
        for (int i = 0; i < pwmfd_pkg::FRAME_LEN; i++) o_status.bytes[i] = r_frame[i];
    end

endmodule

// ===== hdl/pulse_width_manchester_frame_decoder.sv =====
// top level of the pulse width manchester frame decoder
// usage:
//   input channel (i_in_valid / o_in_ready) carries one word per edge event:
//   i_req_type 0 is a line edge with polarity i_edge_rising and the width
//   i_pulse_len in T of the pulse that ends there, i_req_type 1 clears the
//   message-ready flag and restarts framing
//   output channel (o_out_valid / i_out_ready) gives one word per input word:
//   the message-ready flag and the four held frame bytes after that update
//   result path: an accepted word passes the input register, then the state
//   update that also forms the result register
//   throughput: one word per cycle while results are taken; the state update
//   is a single short combinational step between the input and state registers
//   receiver stall: result and all decoder state hold, an empty input register
//   still takes one more word, then o_in_ready drops until the result is taken
//   configuration: i_cfg_we writes i_cfg_data to i_cfg_index (0 wake minimum,
//   1 wake maximum); the user must write only while the block is idle (unchecked)
//   reset: synchronous active low, machine idle, counters and frame bytes zero,
//   wake limits back to 5 and 40, both channels empty
`include "pulse_width_manchester_frame_decoder_defines.svh"

module pulse_width_manchester_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic                              i_edge_rising,
    input  logic [pwmfd_pkg::WIDTH_W-1:0]     i_pulse_len,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_message_ready,
    output logic [pwmfd_pkg::BYTE_W-1:0]      o_target_byte,
    output logic [pwmfd_pkg::BYTE_W-1:0]      o_command_byte,
    output logic [pwmfd_pkg::BYTE_W-1:0]      o_param0_byte,
    output logic [pwmfd_pkg::BYTE_W-1:0]      o_param1_byte,
    input  logic                              i_cfg_we,
    input  logic [pwmfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwmfd_pkg::CFG_W-1:0]       i_cfg_data
);

    logic                         r_in_valid, n_in_valid;
    pwmfd_pkg::t_evt              r_evt;
    logic                         r_out_valid, n_out_valid;
    logic [pwmfd_pkg::CFG_W-1:0]  r_wake_min;
    logic [pwmfd_pkg::CFG_W-1:0]  r_wake_max;
    logic                         advance;
    logic                         in_take;
    pwmfd_pkg::t_frame_status     status;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_evt.req_type    <= i_req_type;
            r_evt.edge_rising <= i_edge_rising;
            r_evt.pulse_len   <= i_pulse_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_min <= pwmfd_pkg::WAKE_MIN_RST;
            r_wake_max <= pwmfd_pkg::WAKE_MAX_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pwmfd_pkg::REG_WAKE_MIN) r_wake_min <= i_cfg_data;
            if (i_cfg_index == pwmfd_pkg::REG_WAKE_MAX) r_wake_max <= i_cfg_data;
        end
    end

    pwmfd_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_evt      (r_evt),
        .i_wake_min (r_wake_min),
        .i_wake_max (r_wake_max),
        .o_status   (status)
    );

    assign o_out_valid     = r_out_valid;
    assign o_message_ready = status.message_ready;
    assign o_target_byte   = status.bytes[0];
    assign o_command_byte  = status.bytes[1];
    assign o_param0_byte   = status.bytes[2];
    assign o_param1_byte   = status.bytes[3];

    `PWMFD_ASSERT_NEXT(a_clear_drops_ready, advance && r_evt.req_type, !o_message_ready,
        "clear request did not drop message ready")
    `PWMFD_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(status),
        "frame status changed without a word advancing")
    `PWMFD_ASSERT_NOW(a_empty_takes_word, !r_out_valid, o_in_ready,
        "input blocked while result register is empty")

endmodule
